>>> rtl/core/mwce_pkg.sv
// mwce_pkg: shared codes, constants and control structs of the melt wipe column engine
// depends on nothing; used by mwce_ctrl, mwce_dp and melt_wipe_column_engine_core
package mwce_pkg;

	// item modes
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_QUERY = 2'd2;
	localparam logic [1:0] MODE_NOP   = 2'd3;

	// register indexes on the config port
	localparam logic [1:0] REG_COLUMN_COUNT  = 2'd0;
	localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd1;
	localparam logic [1:0] REG_ROW_SCALE     = 2'd2;

	// register reset values
	localparam logic [9:0]  RST_COLUMN_COUNT  = 10'd160;
	localparam logic [10:0] RST_SCREEN_HEIGHT = 11'd200;
	localparam logic [3:0]  RST_ROW_SCALE     = 4'd1;

	// step rule: offset+1 below the fast limit, else a fixed slow step; times row_scale
	localparam int FAST_LIMIT = 16;
	localparam int SLOW_STEP  = 8;

	typedef struct packed {
		logic accept;     // input beat taken this cycle
		logic load_wr;    // write the latched load offset
		logic qread;      // read the queried column
		logic sweep_run;  // sweep reads may issue
		logic res_load;   // capture the result beat into the output register
	} cmd_t;

	typedef struct packed {
		logic sweep_idle; // no reads left and the update pipe is empty
	} sts_t;

endpackage

>>> rtl/core/mwce_ctrl.sv
// mwce_ctrl: item sequencer and output beat valid of the melt wipe column engine
// depends on mwce_pkg (cmd_t, sts_t, mode codes)
module mwce_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         mode,
	input  logic               out_ready,
	input  mwce_pkg::sts_t     sts,
	output mwce_pkg::cmd_t     cmd,
	output logic               in_ready,
	output logic               out_valid
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_QRD,
		S_SWEEP,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;

	always_comb begin
		cmd.accept    = in_valid && (state_q == S_IDLE);
		cmd.load_wr   = (state_q == S_LOAD);
		cmd.qread     = (state_q == S_QRD);
		cmd.sweep_run = (state_q == S_SWEEP);
		cmd.res_load  = (state_q == S_FINISH) && (!out_valid_q || out_ready);
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (mode)
							mwce_pkg::MODE_LOAD:  state_q <= S_LOAD;
							mwce_pkg::MODE_QUERY: state_q <= S_QRD;
							mwce_pkg::MODE_TICK:  state_q <= S_SWEEP;
							default:              state_q <= S_FINISH;
						endcase
					end
				end
				S_LOAD:  state_q <= S_FINISH;
				S_QRD:   state_q <= S_FINISH;
				S_SWEEP: begin
					if (sts.sweep_idle) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/mwce_dp.sv
// mwce_dp: offset memory, column sweep pipe, query logic and output register
// depends on mwce_pkg (cmd_t, sts_t, mode codes, step constants)
module mwce_dp #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_HEIGHT  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  mwce_pkg::cmd_t     cmd,
	output mwce_pkg::sts_t     sts,
	input  logic [1:0]         mode,
	input  logic [8:0]         column,
	input  logic signed [7:0]  start_offset,
	input  logic [9:0]         row,
	input  logic [9:0]         column_count,
	input  logic [10:0]        screen_height,
	input  logic [3:0]         row_scale,
	output logic               done_res,
	output logic               from_end_screen,
	output logic [9:0]         source_row
);

	localparam int AW    = $clog2(MAX_COLUMNS);
	localparam int CW    = $clog2(MAX_COLUMNS + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int MAG_W = (HW > 8) ? HW : 8;
	localparam int OFF_W = MAG_W + 1;
	localparam int SUM_W = $clog2(MAX_HEIGHT + 256);
	localparam int QW    = (MAG_W > 10) ? MAG_W : 10;

	// latched item
	logic [1:0]        mode_q;
	logic [8:0]        col_q;
	logic signed [7:0] start_q;
	logic [9:0]        row_q;

	// offset memory
	logic signed [OFF_W-1:0] mem [MAX_COLUMNS];
	logic signed [OFF_W-1:0] rd_q;
	logic                    re;
	logic [AW-1:0]           raddr;
	logic                    we;
	logic [AW-1:0]           waddr;
	logic signed [OFF_W-1:0] wdata;

	// effective limits
	logic [CW-1:0] cnt_eff;
	logic [HW-1:0] height_eff;

	// sweep pipe
	logic [CW-1:0]           idx_q;
	logic                    sweep_more;
	logic                    v_s1;
	logic [AW-1:0]           addr_s1;
	logic                    v_s2;
	logic [AW-1:0]           addr_s2;
	logic                    neg_s2;
	logic                    move_s2;
	logic signed [OFF_W-1:0] off_s2;
	logic [8:0]              prod_s2;
	logic                    changed_q;

	logic               off_neg;
	logic [MAG_W-1:0]   off_mag;
	logic               below_h;
	logic [4:0]         base;
	logic [8:0]         prod;
	logic [SUM_W-1:0]   sum;
	logic signed [OFF_W-1:0] new_off;

	// query
	logic       col_ok;
	logic       q_pos;
	logic [QW-1:0] row_w;
	logic [QW-1:0] off_w;
	logic       q_end;
	logic [9:0] q_src;

	// result register
	logic       done_q;
	logic       fe_q;
	logic [9:0] src_q;

	assign cnt_eff    = (32'(column_count) > MAX_COLUMNS) ? CW'(MAX_COLUMNS) : CW'(column_count);
	assign height_eff = (32'(screen_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(screen_height);
	assign col_ok     = (32'(col_q) < MAX_COLUMNS);

	assign sweep_more     = (idx_q < cnt_eff);
	assign sts.sweep_idle = !sweep_more && !v_s1 && !v_s2;

	// read port: query read or sweep read
	always_comb begin
		re    = 1'b0;
		raddr = idx_q[AW-1:0];
		if (cmd.qread) begin
			re    = 1'b1;
			raddr = AW'(col_q);
		end else if (cmd.sweep_run && sweep_more) begin
			re = 1'b1;
		end
	end

	// stage 1: classify the offset read back and form the scaled step
	always_comb begin
		off_neg = rd_q[OFF_W-1];
		off_mag = rd_q[MAG_W-1:0];
		below_h = !off_neg && (off_mag < MAG_W'(height_eff));
		base    = (off_mag < MAG_W'(mwce_pkg::FAST_LIMIT)) ? (5'(off_mag) + 5'd1)
		                                                   : 5'(mwce_pkg::SLOW_STEP);
		prod    = 9'(base) * 9'(row_scale);
	end

	// stage 2: add the step, clamp at the height; a negative offset steps up by one
	always_comb begin
		sum = SUM_W'(off_s2[MAG_W-1:0]) + SUM_W'(prod_s2);
		if (neg_s2) begin
			new_off = off_s2 + OFF_W'(1);
		end else if (sum >= SUM_W'(height_eff)) begin
			new_off = OFF_W'(height_eff);
		end else begin
			new_off = OFF_W'(sum);
		end
	end

	// write port: sweep write-back wins, loads only happen outside a sweep
	always_comb begin
		we    = 1'b0;
		waddr = addr_s2;
		wdata = new_off;
		if (v_s2 && (neg_s2 || move_s2)) begin
			we = 1'b1;
		end else if (cmd.load_wr && col_ok) begin
			we    = 1'b1;
			waddr = AW'(col_q);
			wdata = OFF_W'(start_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	// query answer
	always_comb begin
		q_pos = col_ok && !rd_q[OFF_W-1] && (rd_q != '0);
		row_w = QW'(row_q);
		off_w = QW'(rd_q[MAG_W-1:0]);
		q_end = q_pos && (row_w < off_w);
		q_src = (q_pos && !q_end) ? 10'(row_w - off_w) : row_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			mode_q  <= mode;
			col_q   <= column;
			start_q <= start_offset;
			row_q   <= row;
		end
		addr_s1 <= idx_q[AW-1:0];
		addr_s2 <= addr_s1;
		off_s2  <= rd_q;
		neg_s2  <= off_neg;
		move_s2 <= below_h;
		prod_s2 <= prod;
		if (cmd.res_load) begin
			done_q <= (mode_q == mwce_pkg::MODE_TICK) && !changed_q;
			fe_q   <= (mode_q == mwce_pkg::MODE_QUERY) && q_end;
			src_q  <= (mode_q == mwce_pkg::MODE_QUERY) ? q_src : 10'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			changed_q <= 1'b0;
		end else begin
			v_s1 <= cmd.sweep_run && sweep_more;
			v_s2 <= v_s1;
			if (cmd.accept && (mode == mwce_pkg::MODE_TICK)) begin
				idx_q     <= '0;
				changed_q <= 1'b0;
			end else begin
				if (cmd.sweep_run && sweep_more) begin
					idx_q <= idx_q + CW'(1);
				end
				if (v_s1 && (off_neg || below_h)) begin
					changed_q <= 1'b1;
				end
			end
		end
	end

	assign done_res        = done_q;
	assign from_end_screen = fe_q;
	assign source_row      = src_q;

endmodule

>>> rtl/core/melt_wipe_column_engine_core.sv
// melt wipe column engine: after the accept a load writes or a query reads its offset,
// a no-op goes to the result, and a tick sweeps min(column_count, MAX_COLUMNS) columns:
// one column read a cycle through the single read port, then a two-stage update pipe drains
// one item in flight; the next beat is taken the cycle after capture while the result may
// still wait at the output; a result is captured when no beat waits there or it is taken
// arst_n clears sequencer, sweep pipe and registers to 160/200/1; offset memory not cleared
module melt_wipe_column_engine_core #(
	parameter int MAX_COLUMNS = 512,
	parameter int MAX_HEIGHT  = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	// config port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// item channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [8:0]         column,
	input  logic signed [7:0]  start_offset,
	input  logic [9:0]         row,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               done_res,
	output logic               from_end_screen,
	output logic [9:0]         source_row
);

	// config registers
	logic [9:0]  column_count_q;
	logic [10:0] screen_height_q;
	logic [3:0]  row_scale_q;
	logic        cfg_wr;

	mwce_pkg::cmd_t cmd;
	mwce_pkg::sts_t sts;

	// zero-wait config port, write lands on the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q  <= mwce_pkg::RST_COLUMN_COUNT;
			screen_height_q <= mwce_pkg::RST_SCREEN_HEIGHT;
			row_scale_q     <= mwce_pkg::RST_ROW_SCALE;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				mwce_pkg::REG_COLUMN_COUNT:  column_count_q  <= pwdata[9:0];
				mwce_pkg::REG_SCREEN_HEIGHT: screen_height_q <= pwdata[10:0];
				mwce_pkg::REG_ROW_SCALE:     row_scale_q     <= pwdata[3:0];
				default: ; // unmapped word, write dropped
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (paddr[3:2])
			mwce_pkg::REG_COLUMN_COUNT:  prdata = 32'(column_count_q);
			mwce_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_q);
			mwce_pkg::REG_ROW_SCALE:     prdata = 32'(row_scale_q);
			default:                     prdata = 32'd0;
		endcase
	end

	// sequencer: one item at a time, result beat parked in the output register
	mwce_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.in_ready  (in_ready),
		.out_valid (out_valid)
	);

	// offset store, sweep pipe and query logic
	mwce_dp #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_HEIGHT  (MAX_HEIGHT)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.column          (column),
		.start_offset    (start_offset),
		.row             (row),
		.column_count    (column_count_q),
		.screen_height   (screen_height_q),
		.row_scale       (row_scale_q),
		.done_res        (done_res),
		.from_end_screen (from_end_screen),
		.source_row      (source_row)
	);

	// a new result never overwrites a beat still waiting at the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid || out_ready))
		else $error("result captured over a pending output beat");

	// only one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in flight");

	// a beat carries either a tick answer or a query answer, never both
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(done_res && from_end_screen))
		else $error("tick and query flags both set on one beat");

endmodule
